/* rtl/wia_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wia_pkg
// Shared types, opcodes and helpers of the 128-bit integer ALU.
// ----------------------------------------------------------------------------
package wia_pkg;

    localparam int WORD_W  = 128;
    localparam int HALF_W  = 64;
    localparam int LIMB_W  = 32;
    localparam int SHAMT_W = 8;
    localparam int OP_W    = 3;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [OP_W-1:0]    t_opcode;
    typedef logic [SHAMT_W-1:0] t_shamt;

    // operation codes
    localparam t_opcode OP_ADD = 3'd0;
    localparam t_opcode OP_SUB = 3'd1;
    localparam t_opcode OP_MUL = 3'd2;
    localparam t_opcode OP_NEG = 3'd3;
    localparam t_opcode OP_SHL = 3'd4;
    localparam t_opcode OP_SHR = 3'd5;
    localparam t_opcode OP_SAR = 3'd6;

    // shifter command: direction, fill bit and distance
    typedef struct packed {
        logic   left;
        logic   fill;
        t_shamt amount;
    } t_shift_cmd;

    // control that travels down the pipeline with each transaction
    typedef struct packed {
        logic    valid;
        t_opcode opcode;
    } t_ctrl;

    // mirror a word end to end, turns a left shift into a right shift
    function automatic t_word bit_reverse(t_word x);
        t_word r;
        for (int k = 0; k < WORD_W; k++) begin
            r[k] = x[WORD_W-1-k];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/wia_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wia_mul
// Pipelined 128x128 multiplier keeping the low 128 bits of the product.
// ----------------------------------------------------------------------------
module wia_mul (
    input  wire logic          i_clk,
    input  wire wia_pkg::t_word i_a,
    input  wire wia_pkg::t_word i_b,
    output wia_pkg::t_word      o_product
);
    import wia_pkg::*;

    // 32x32 partial products, only those below bit 128
    logic [2*LIMB_W-1:0] r_p00, r_p01, r_p10, r_p02, r_p11, r_p20;
    logic [LIMB_W-1:0]   r_p03, r_p12, r_p21, r_p30;
    // column group sums
    logic [2*LIMB_W-1:0] r_g0;
    logic [2*LIMB_W:0]   r_g1;
    logic [2*LIMB_W+1:0] r_g2;
    logic [LIMB_W-1:0]   r_g3;
    // two partial words
    t_word               r_part_lo;
    t_half               r_part_hi;

    function automatic logic [2*LIMB_W-1:0] limb_mul(logic [LIMB_W-1:0] x,
                                                     logic [LIMB_W-1:0] y);
        return (2*LIMB_W)'(x) * (2*LIMB_W)'(y);
    endfunction

    // stage: limb products
    always_ff @(posedge i_clk) begin
        r_p00 <= limb_mul(i_a[0*LIMB_W +: LIMB_W], i_b[0*LIMB_W +: LIMB_W]);
        r_p01 <= limb_mul(i_a[0*LIMB_W +: LIMB_W], i_b[1*LIMB_W +: LIMB_W]);
        r_p10 <= limb_mul(i_a[1*LIMB_W +: LIMB_W], i_b[0*LIMB_W +: LIMB_W]);
        r_p02 <= limb_mul(i_a[0*LIMB_W +: LIMB_W], i_b[2*LIMB_W +: LIMB_W]);
        r_p11 <= limb_mul(i_a[1*LIMB_W +: LIMB_W], i_b[1*LIMB_W +: LIMB_W]);
        r_p20 <= limb_mul(i_a[2*LIMB_W +: LIMB_W], i_b[0*LIMB_W +: LIMB_W]);
        r_p03 <= LIMB_W'(i_a[0*LIMB_W +: LIMB_W] * i_b[3*LIMB_W +: LIMB_W]);
        r_p12 <= LIMB_W'(i_a[1*LIMB_W +: LIMB_W] * i_b[2*LIMB_W +: LIMB_W]);
        r_p21 <= LIMB_W'(i_a[2*LIMB_W +: LIMB_W] * i_b[1*LIMB_W +: LIMB_W]);
        r_p30 <= LIMB_W'(i_a[3*LIMB_W +: LIMB_W] * i_b[0*LIMB_W +: LIMB_W]);
    end

    // stage: sum products that share a column weight
    always_ff @(posedge i_clk) begin
        r_g0 <= r_p00;
        r_g1 <= (2*LIMB_W+1)'(r_p01) + (2*LIMB_W+1)'(r_p10);
        r_g2 <= (2*LIMB_W+2)'(r_p02) + (2*LIMB_W+2)'(r_p11) + (2*LIMB_W+2)'(r_p20);
        r_g3 <= r_p03 + r_p12 + r_p21 + r_p30;
    end

    // stage: fold columns into a low word and an upper half
    always_ff @(posedge i_clk) begin
        r_part_lo <= WORD_W'(r_g0) + (WORD_W'(r_g1) << LIMB_W);
        r_part_hi <= r_g2[HALF_W-1:0] + {r_g3, {LIMB_W{1'b0}}};
    end

    // final add, registered by the result stage
    assign o_product = r_part_lo + {r_part_hi, {HALF_W{1'b0}}};

endmodule
`default_nettype wire

/* rtl/wia_addsub.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wia_addsub
// 128-bit add, subtract and negate with a delay line to the result stage.
// ----------------------------------------------------------------------------
module wia_addsub (
    input  wire logic            i_clk,
    input  wire wia_pkg::t_opcode i_opcode,
    input  wire wia_pkg::t_word   i_a,
    input  wire wia_pkg::t_word   i_b,
    output wia_pkg::t_word        o_sum
);
    import wia_pkg::*;

    t_word n_sum;
    t_word r_s2, r_s3, r_s4;

    // one adder: a+b, a+~b+1, ~a+0+1
    always_comb begin
        t_word x;
        t_word y;
        logic  cin;
        x   = (i_opcode == OP_NEG) ? ~i_a : i_a;
        cin = (i_opcode != OP_ADD);
        unique case (i_opcode)
            OP_ADD:  y = i_b;
            OP_SUB:  y = ~i_b;
            default: y = '0;
        endcase
        n_sum = x + y + WORD_W'(cin);
    end

    // align with the multiplier
    always_ff @(posedge i_clk) begin
        r_s2 <= n_sum;
        r_s3 <= r_s2;
        r_s4 <= r_s3;
    end

    assign o_sum = r_s4;

endmodule
`default_nettype wire

/* rtl/wia_shift.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wia_shift
// Three-stage 128-bit barrel shifter for logical and arithmetic shifts.
// ----------------------------------------------------------------------------
module wia_shift (
    input  wire logic               i_clk,
    input  wire wia_pkg::t_shift_cmd i_cmd,
    input  wire wia_pkg::t_word      i_a,
    output wia_pkg::t_word           o_shifted
);
    import wia_pkg::*;

    t_shift_cmd r_cmd2, r_cmd3;
    t_word      r_s2, r_s3, r_s4;
    t_word      n_s2, n_s3, n_s4;

    // right shift by a constant distance, filling from the top
    function automatic t_word shr_fill(t_word x, logic fill, int shift_dist);
        logic [2*WORD_W-1:0] w;
        w = {{WORD_W{fill}}, x} >> shift_dist;
        return w[WORD_W-1:0];
    endfunction

    // first levels: saturation and distances 64, 32
    always_comb begin
        t_word x;
        x = i_cmd.left ? bit_reverse(i_a) : i_a;
        for (int k = 6; k >= 5; k--) begin
            if (i_cmd.amount[k]) x = shr_fill(x, i_cmd.fill, 1 << k);
        end
        if (i_cmd.amount[SHAMT_W-1]) x = {WORD_W{i_cmd.fill}};
        n_s2 = x;
    end

    // middle levels: distances 16, 8, 4
    always_comb begin
        t_word x;
        x = r_s2;
        for (int k = 4; k >= 2; k--) begin
            if (r_cmd2.amount[k]) x = shr_fill(x, r_cmd2.fill, 1 << k);
        end
        n_s3 = x;
    end

    // last levels: distances 2, 1, then undo the mirror for left shifts
    always_comb begin
        t_word x;
        x = r_s3;
        for (int k = 1; k >= 0; k--) begin
            if (r_cmd3.amount[k]) x = shr_fill(x, r_cmd3.fill, 1 << k);
        end
        n_s4 = r_cmd3.left ? bit_reverse(x) : x;
    end

    always_ff @(posedge i_clk) begin
        r_cmd2 <= i_cmd;
        r_cmd3 <= r_cmd2;
        r_s2   <= n_s2;
        r_s3   <= n_s3;
        r_s4   <= n_s4;
    end

    assign o_shifted = r_s4;

endmodule
`default_nettype wire

/* rtl/wide_integer_alu_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wide_integer_alu_top
// 128-bit two's complement ALU: add, sub, mul, negate and three shifts.
// ----------------------------------------------------------------------------
// Usage:
// - a transaction is taken at a rising edge with start high and busy low;
//   busy is always low, so one transaction can enter on every cycle
// - operands come as 64-bit halves, the shift distance as 8 bits; a
//   distance of 128 or more gives zero, or all sign bits for sar
// - each result appears on o_result_low/o_result_high for one cycle with
//   o_done high, from the result register at the end of the pipeline
// - results leave in the order the transactions came in
// - throughput is one transaction per cycle; latency is set by the
//   multiplier: limb products, column sums, partial words, final add
// - add/sub/negate and the barrel shifter are delayed to the same depth
// - unused opcode 7 returns zero
// - synchronous active-low reset clears the valid bits of every stage,
//   so no strobe appears until new transactions arrive
// - the receiver cannot stall; no results are ever held back
// ----------------------------------------------------------------------------
module wide_integer_alu_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire wia_pkg::t_opcode i_opcode,
    input  wire wia_pkg::t_half   i_a_low,
    input  wire wia_pkg::t_half   i_a_high,
    input  wire wia_pkg::t_half   i_b_low,
    input  wire wia_pkg::t_half   i_b_high,
    input  wire wia_pkg::t_shamt  i_shift_amount,
    output logic                 o_done,
    output wia_pkg::t_half        o_result_low,
    output wia_pkg::t_half        o_result_high
);
    import wia_pkg::*;

    t_ctrl      r_ctrl1, r_ctrl2, r_ctrl3, r_ctrl4;
    t_word      r_a, r_b;
    t_shift_cmd r_cmd;
    t_word      w_product, w_sum, w_shifted;
    t_word      n_result;
    t_word      r_result;
    logic       r_done;
    logic       w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // input stage: operands and shifter command
    always_ff @(posedge i_clk) begin
        r_a          <= {i_a_high, i_a_low};
        r_b          <= {i_b_high, i_b_low};
        r_cmd.left   <= (i_opcode == OP_SHL);
        r_cmd.fill   <= (i_opcode == OP_SAR) && i_a_high[HALF_W-1];
        r_cmd.amount <= i_shift_amount;
    end

    // valid bits and opcode travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1.valid <= 1'b0;
            r_ctrl2.valid <= 1'b0;
            r_ctrl3.valid <= 1'b0;
            r_ctrl4.valid <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_ctrl1.valid <= w_accept;
            r_ctrl2.valid <= r_ctrl1.valid;
            r_ctrl3.valid <= r_ctrl2.valid;
            r_ctrl4.valid <= r_ctrl3.valid;
            r_done        <= r_ctrl4.valid;
        end
        r_ctrl1.opcode <= i_opcode;
        r_ctrl2.opcode <= r_ctrl1.opcode;
        r_ctrl3.opcode <= r_ctrl2.opcode;
        r_ctrl4.opcode <= r_ctrl3.opcode;
    end

    wia_mul u_mul (
        .i_clk     (i_clk),
        .i_a       (r_a),
        .i_b       (r_b),
        .o_product (w_product)
    );

    wia_addsub u_addsub (
        .i_clk    (i_clk),
        .i_opcode (r_ctrl1.opcode),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_sum    (w_sum)
    );

    wia_shift u_shift (
        .i_clk     (i_clk),
        .i_cmd     (r_cmd),
        .i_a       (r_a),
        .o_shifted (w_shifted)
    );

    // result select
    always_comb begin
        unique case (r_ctrl4.opcode)
            OP_ADD, OP_SUB, OP_NEG: n_result = w_sum;
            OP_MUL:                 n_result = w_product;
            OP_SHL, OP_SHR, OP_SAR: n_result = w_shifted;
            default:                n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done        = r_done;
    assign o_result_low  = r_result[HALF_W-1:0];
    assign o_result_high = r_result[WORD_W-1:HALF_W];

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the 128-bit integer ALU against a predictor that uses native
// 128-bit arithmetic. A directed set covers wraparound, negation of the
// most negative value, shift distances at and around the half and word
// boundaries, long shifts and the unused opcode. A random stream with
// corner-biased operands follows. Gaps of random length fall between some
// transactions; each result is matched in order against the predicted word.
// ----------------------------------------------------------------------------
module testbench;
    import wia_pkg::*;

    localparam t_opcode OP_UNUSED  = 3'd7;
    localparam int      RANDOM_OPS = 1150;
    localparam int      IDLE_LIMIT = 2000;
    localparam int      DRAIN_CYC  = 12;

    // expected result words and their predictor
    class alu_result_checker;
        t_word pending_results[$];
        int    err_count;

        function new();
            err_count = 0;
        endfunction

        // what the alu should produce for one transaction
        function t_word compute_alu(t_opcode op, t_word a, t_word b, t_shamt n);
            t_word r;
            case (op)
                OP_ADD:  r = a + b;
                OP_SUB:  r = a - b;
                OP_MUL:  r = a * b;
                OP_NEG:  r = -a;
                OP_SHL:  r = (n < 8'd128) ? (a << n) : '0;
                OP_SHR:  r = (n < 8'd128) ? (a >> n) : '0;
                OP_SAR:  r = t_word'($signed(a) >>> n);
                default: r = '0;
            endcase
            return r;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            err_count++;
        endtask

        task note_input(t_opcode op, t_word a, t_word b, t_shamt n);
            pending_results.push_back(compute_alu(op, a, b, n));
        endtask

        task check_result(t_half lo, t_half hi);
            t_word exp_word;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h_%h with no transaction pending", hi, lo));
            end else begin
                exp_word = pending_results.pop_front();
                if (lo !== exp_word[HALF_W-1:0])
                    report($sformatf("result_low %h, expected %h",
                                     lo, exp_word[HALF_W-1:0]));
                if (hi !== exp_word[WORD_W-1:HALF_W])
                    report($sformatf("result_high %h, expected %h",
                                     hi, exp_word[WORD_W-1:HALF_W]));
            end
        endtask
    endclass

    logic    i_clk          = 1'b0;
    logic    i_rst_n        = 1'b0;
    logic    start          = 1'b0;
    t_opcode i_opcode       = OP_ADD;
    t_half   i_a_low        = '0;
    t_half   i_a_high       = '0;
    t_half   i_b_low        = '0;
    t_half   i_b_high       = '0;
    t_shamt  i_shift_amount = '0;
    logic    busy;
    logic    o_done;
    t_half   o_result_low;
    t_half   o_result_high;

    alu_result_checker results;
    int                idle_cycles = 0;

    wide_integer_alu_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_a_low        (i_a_low),
        .i_a_high       (i_a_high),
        .i_b_low        (i_b_low),
        .i_b_high       (i_b_high),
        .i_shift_amount (i_shift_amount),
        .o_done         (o_done),
        .o_result_low   (o_result_low),
        .o_result_high  (o_result_high)
    );

    always #5 i_clk = ~i_clk;

    // monitor both sides and watch for a stalled run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                results.note_input(i_opcode, {i_a_high, i_a_low},
                                   {i_b_high, i_b_low}, i_shift_amount);
            if (o_done)
                results.check_result(o_result_low, o_result_high);
        end
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one transaction and hold it until taken
    task send_op(t_opcode op, t_word a, t_word b, t_shamt n);
        start          <= 1'b1;
        i_opcode       <= op;
        i_a_low        <= a[HALF_W-1:0];
        i_a_high       <= a[WORD_W-1:HALF_W];
        i_b_low        <= b[HALF_W-1:0];
        i_b_high       <= b[WORD_W-1:HALF_W];
        i_shift_amount <= n;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // operand half biased toward the corners
    function t_half pick_half();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7fff_ffff_ffff_ffff;
            4:       return t_half'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function t_shamt pick_shift();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return t_shamt'($urandom_range(0, 127));
        if (r < 8) return t_shamt'($urandom_range(128, 255));
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd63;
            2:       return 8'd64;
            3:       return 8'd65;
            4:       return 8'd127;
            default: return 8'd128;
        endcase
    endfunction

    initial begin
        t_word   max_w;
        t_word   min_w;
        t_word   neg_w;
        t_word   pos_w;
        t_opcode op;
        int      burst_left;
        int      r;

        results    = new();
        max_w      = '1;
        min_w      = {1'b1, {(WORD_W-1){1'b0}}};
        neg_w      = 128'hc3a5_0f0f_1234_5678_9abc_def0_0011_2233;
        pos_w      = 128'h5a5a_f00d_0123_4567_89ab_cdef_fedc_ba98;
        burst_left = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wraparound, negation corners, shift boundaries
        send_op(OP_ADD, max_w, 128'd1, 8'd0);
        send_op(OP_ADD, {64'h0, 64'hffff_ffff_ffff_ffff}, 128'd1, 8'd255);
        send_op(OP_SUB, '0, 128'd1, 8'd0);
        send_op(OP_SUB, min_w, 128'd1, 8'd0);
        send_op(OP_MUL, max_w, max_w, 8'd0);
        send_op(OP_MUL, {64'h1, 64'hffff_ffff_ffff_ffff}, neg_w, 8'd0);
        send_op(OP_NEG, '0, max_w, 8'd0);
        send_op(OP_NEG, min_w, '0, 8'd0);
        send_op(OP_SHL, pos_w, max_w, 8'd0);
        send_op(OP_SHL, max_w, '0, 8'd1);
        send_op(OP_SHL, neg_w, '0, 8'd64);
        send_op(OP_SHL, max_w, '0, 8'd127);
        send_op(OP_SHL, max_w, '0, 8'd128);
        send_op(OP_SHL, max_w, '0, 8'd255);
        send_op(OP_SHR, neg_w, '0, 8'd63);
        send_op(OP_SHR, max_w, '0, 8'd64);
        send_op(OP_SHR, max_w, '0, 8'd200);
        send_op(OP_SAR, neg_w, '0, 8'd0);
        send_op(OP_SAR, neg_w, '0, 8'd1);
        send_op(OP_SAR, min_w, '0, 8'd127);
        send_op(OP_SAR, neg_w, '0, 8'd128);
        send_op(OP_SAR, neg_w, '0, 8'd255);
        send_op(OP_SAR, pos_w, '0, 8'd130);
        send_op(OP_SAR, pos_w, '0, 8'd65);
        send_op(OP_UNUSED, max_w, max_w, 8'd255);
        idle_gap(3);

        // random stream with bursts and gaps of mixed length
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if ($urandom_range(0, 29) == 0)
                op = OP_UNUSED;
            else
                op = t_opcode'($urandom_range(0, 6));
            send_op(op, {pick_half(), pick_half()}, {pick_half(), pick_half()},
                    pick_shift());
            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(20, 60);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    ;
                else if (r < 90)
                    idle_gap($urandom_range(1, 3));
                else
                    idle_gap($urandom_range(8, 40));
            end
        end

        // drain the pipeline
        start <= 1'b0;
        @(posedge i_clk);
        while (results.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (results.err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/wia_pkg.sv
rtl/wia_mul.sv
rtl/wia_addsub.sv
rtl/wia_shift.sv
rtl/wide_integer_alu_top.sv
tb/testbench.sv
